// File: sv/tods_pkg.sv
// Shared types and constants for the time-of-day sync pulse timer.
package tods_pkg;

    // Field and register widths
    localparam int TIME_W  = 32;
    localparam int TICK_W  = 31;
    localparam int PULSE_W = 16;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // Remainder unit: magnitude width of the dividend, two bits per step
    localparam int NUM_W = 34;
    localparam int WIDE_W = NUM_W + 1;
    localparam int STEPS = NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_EXTRA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GPS_LEAD    = 3'd4;

    // Register reset values
    localparam logic [TICK_W-1:0]  DAY_LENGTH_RST  = 31'd86400000;
    localparam logic [TICK_W-1:0]  SYNC_PERIOD_RST = 31'd1000;
    localparam logic [PULSE_W-1:0] SYNC_PULSE_RST  = 16'd100;
    localparam logic [PULSE_W-1:0] SYNC_EXTRA_RST  = 16'd0;
    localparam logic [TICK_W-1:0]  GPS_LEAD_RST    = 31'd500;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_DIV_PER,
        ST_DONE
    } tods_state_t;

endpackage

// File: sv/time_of_day_sync_pulse_timer.sv
// Time-of-day tick counter with period countdown, sync pulse and GPS power strobe.
//
// Each input transfer (tuser = kind, tdata = tick_value) yields one result transfer.
// The sequencer takes a tick item, an add item while the time is not valid or an
// unused kind from idle straight to the done state, where the result register loads.
// A set item, or an add item with valid time, first runs through one shared remainder
// unit that retires two dividend bits per cycle: the remainder by the day length, then,
// unless the new time comes out negative, the remainder by the sync period. s_tready
// is high only while the sequencer is idle; a finished result waits in the output
// register without blocking the next transfer in, and the next result holds the
// sequencer until that register frees up. Registers are written through
// cfg_we/cfg_index/cfg_wdata while no item is in flight; the user must keep to this,
// as the block itself does not enforce it. Indexes past the last register are
// ignored.
module time_of_day_sync_pulse_timer
    import tods_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // [31:0] tick_value
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] time_of_day, [32] time_valid, [33] sync_level,
    // [34] gps_power_strobe, [42:35] sync_count, [47:43] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    tods_state_t state_reg, state_next;

    // Configuration
    logic [TICK_W-1:0]  day_len_reg, period_reg, lead_reg;
    logic [PULSE_W-1:0] pulse_len_reg, extra_reg;

    // Timer state
    logic signed [TIME_W-1:0] day_reg, day_next;
    logic                     valid_reg, valid_next;
    logic [TIME_W-1:0]        cd_reg, cd_next;
    logic [PULSE_W-1:0]       pr_reg, pr_next;
    logic [COUNT_W-1:0]       cnt_pulse_reg, cnt_pulse_next;
    logic                     line_reg, line_next;
    logic                     strobe_reg, strobe_next;

    // Remainder unit
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              a_neg_reg, a_neg_next;
    logic              b_neg_reg, b_neg_next;
    logic [NUM_W-1:0]  b_mag_reg, b_mag_next;

    // Output register
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic                  in_xfer;
    logic                  out_free;
    logic                  last_step;
    logic                  day_rem_neg;
    logic [TICK_W-1:0]     eff_day, eff_per, divisor;
    logic [TICK_W:0]       r1_raw, r2_raw;
    logic [TICK_W-1:0]     r1, rem_step;
    logic signed [WIDE_W-1:0] t_wide, a_wide, b_wide;
    logic [WIDE_W-1:0]     a_abs, b_abs;
    logic signed [TIME_W:0] day_inc;
    logic                  is_load;

    assign eff_day = (day_len_reg == '0) ? TICK_W'(1) : day_len_reg;
    assign eff_per = (period_reg == '0) ? TICK_W'(1) : period_reg;
    assign divisor = (state_reg == ST_DIV_DAY) ? eff_day : eff_per;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_step = (step_reg == CNT_W'(STEPS - 1));
    assign is_load   = (s_tuser == KIND_SET) || ((s_tuser == KIND_ADD) && valid_reg);

    // Two restoring compare-subtract steps of the shared remainder unit
    always_comb begin
        r1_raw = {rem_reg, num_reg[NUM_W-1]};
        r1 = (r1_raw >= {1'b0, divisor}) ? TICK_W'(r1_raw - {1'b0, divisor})
                                         : r1_raw[TICK_W-1:0];
        r2_raw = {r1, num_reg[NUM_W-2]};
        rem_step = (r2_raw >= {1'b0, divisor}) ? TICK_W'(r2_raw - {1'b0, divisor})
                                               : r2_raw[TICK_W-1:0];
    end

    assign day_rem_neg = a_neg_reg && (rem_step != '0);

    // Wide operands for a load: t, t + D and t + D - S - E
    always_comb begin
        if (s_tuser == KIND_SET) begin
            t_wide = WIDE_W'($signed(s_tdata));
        end else begin
            t_wide = WIDE_W'(day_reg) + WIDE_W'($signed(s_tdata));
        end
        a_wide = t_wide + $signed({{(WIDE_W-TICK_W){1'b0}}, eff_day});
        b_wide = a_wide - $signed({{(WIDE_W-PULSE_W){1'b0}}, pulse_len_reg})
                        - $signed({{(WIDE_W-PULSE_W){1'b0}}, extra_reg});
        a_abs = a_wide[WIDE_W-1] ? WIDE_W'(-a_wide) : WIDE_W'(a_wide);
        b_abs = b_wide[WIDE_W-1] ? WIDE_W'(-b_wide) : WIDE_W'(b_wide);
    end

    assign day_inc = (TIME_W+1)'(day_reg) + (TIME_W+1)'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = is_load ? ST_DIV_DAY : ST_DONE;
                end
            end
            ST_DIV_DAY: begin
                if (last_step) begin
                    state_next = day_rem_neg ? ST_DONE : ST_DIV_PER;
                end
            end
            ST_DIV_PER: begin
                if (last_step) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_DIV_DAY: s_tready = 1'b0;
            ST_DIV_PER: s_tready = 1'b0;
            ST_DONE:    s_tready = 1'b0;
            default:    s_tready = 1'b0;
        endcase
    end

    // Datapath
    always_comb begin
        day_next       = day_reg;
        valid_next     = valid_reg;
        cd_next        = cd_reg;
        pr_next        = pr_reg;
        cnt_pulse_next = cnt_pulse_reg;
        line_next      = line_reg;
        strobe_next    = strobe_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        a_neg_next     = a_neg_reg;
        b_neg_next     = b_neg_reg;
        b_mag_next     = b_mag_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    strobe_next = 1'b0;
                    step_next   = '0;
                    rem_next    = '0;
                    num_next    = a_abs[NUM_W-1:0];
                    a_neg_next  = a_wide[WIDE_W-1];
                    b_neg_next  = b_wide[WIDE_W-1];
                    b_mag_next  = b_abs[NUM_W-1:0];
                    if (s_tuser == KIND_TICK) begin
                        if (day_inc >= $signed({2'b00, eff_day})) begin
                            day_next = '0;
                        end else begin
                            day_next = day_inc[TIME_W-1:0];
                        end
                        strobe_next = (cd_reg == {1'b0, lead_reg});
                        if (cd_reg == TIME_W'(1)) begin
                            cd_next = {1'b0, eff_per};
                            if (valid_reg) begin
                                pr_next        = pulse_len_reg;
                                line_next      = 1'b1;
                                cnt_pulse_next = cnt_pulse_reg + COUNT_W'(1);
                            end
                        end else begin
                            cd_next = cd_reg - TIME_W'(1);
                            if (pr_reg != '0) begin
                                pr_next = pr_reg - PULSE_W'(1);
                                // drop the line as the pulse runs out
                                if (pr_reg == PULSE_W'(1)) begin
                                    line_next = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            ST_DIV_DAY, ST_DIV_PER: begin
                rem_next  = rem_step;
                num_next  = {num_reg[NUM_W-3:0], 2'b00};
                step_next = step_reg + CNT_W'(1);
                if (last_step) begin
                    step_next = '0;
                    rem_next  = '0;
                    num_next  = b_mag_reg;
                    if (state_reg == ST_DIV_DAY) begin
                        day_next = a_neg_reg ? -$signed({1'b0, rem_step})
                                             : $signed({1'b0, rem_step});
                        if (!day_rem_neg) begin
                            valid_next = 1'b1;
                        end
                    end else begin
                        cd_next = b_neg_reg ? (TIME_W'(eff_per) + TIME_W'(rem_step))
                                            : (TIME_W'(eff_per) - TIME_W'(rem_step));
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b00000, cnt_pulse_reg, strobe_reg, line_reg,
                                     valid_reg, day_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            day_reg       <= '0;
            valid_reg     <= 1'b0;
            cd_reg        <= {1'b0, SYNC_PERIOD_RST};
            pr_reg        <= '0;
            cnt_pulse_reg <= '0;
            line_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            day_reg       <= day_next;
            valid_reg     <= valid_next;
            cd_reg        <= cd_next;
            pr_reg        <= pr_next;
            cnt_pulse_reg <= cnt_pulse_next;
            line_reg      <= line_next;
            strobe_reg    <= strobe_next;
            step_reg      <= step_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        a_neg_reg   <= a_neg_next;
        b_neg_reg   <= b_neg_next;
        b_mag_reg   <= b_mag_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_len_reg   <= DAY_LENGTH_RST;
            period_reg    <= SYNC_PERIOD_RST;
            pulse_len_reg <= SYNC_PULSE_RST;
            extra_reg     <= SYNC_EXTRA_RST;
            lead_reg      <= GPS_LEAD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DAY_LENGTH:  day_len_reg   <= cfg_wdata[TICK_W-1:0];
                CFG_SYNC_PERIOD: period_reg    <= cfg_wdata[TICK_W-1:0];
                CFG_SYNC_PULSE:  pulse_len_reg <= cfg_wdata[PULSE_W-1:0];
                CFG_SYNC_EXTRA:  extra_reg     <= cfg_wdata[PULSE_W-1:0];
                CFG_GPS_LEAD:    lead_reg      <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // The countdown reloads before it reaches zero
    a_cd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cd_reg != '0)
        else $error("period countdown reached zero");

    // The partial remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_DAY || state_reg == ST_DIV_PER) |-> (rem_reg < divisor))
        else $error("partial remainder out of range");

    // An accepted transfer closes the input until its result is registered
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

endmodule
